[sv/ucdscan_pkg.sv]
package ucdscan_pkg;

  localparam int SLOTS_DEFAULT        = 4;
  localparam int BUFFER_BYTES_DEFAULT = 512;

  localparam int BYTE_W  = 8;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_SLOT_IF = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_SLOT_IF  = 1'd1;

  localparam logic [7:0] FIRST_SLOT_IF_RESET = 8'd0;
  localparam logic [7:0] LAST_SLOT_IF_RESET  = 8'd3;

  localparam logic [7:0] DESC_INTERFACE = 8'h04;
  localparam logic [7:0] DESC_ENDPOINT  = 8'h05;
  localparam logic [7:0] IFACE_NONE     = 8'hff;
  localparam int         EP_DIR_IN_BIT  = 7;
  localparam logic [1:0] XFER_INTERRUPT = 2'd3;

  localparam logic [7:0] MIN_HDR_LEN = 8'd2;
  localparam logic [7:0] MIN_EP_LEN  = 8'd7;
  localparam logic [7:0] MIN_IF_LEN  = 8'd9;

  localparam int TOTAL_LO_OFS = 2;
  localparam int TOTAL_HI_OFS = 3;
  localparam int REL_ADDR     = 2;
  localparam int REL_ATTR     = 3;
  localparam int REL_MPS_LO   = 4;
  localparam int REL_MPS_HI   = 5;
  localparam int REL_INTERVAL = 6;

  localparam logic CAUSE_USED_UP   = 1'b0;
  localparam logic CAUSE_MALFORMED = 1'b1;

  typedef struct packed {
    logic             restart;
    logic [BYTE_W-1:0] desc_byte;
  } item_t;

  typedef struct packed {
    logic        map_valid;
    logic [1:0]  slot_index;
    logic [7:0]  endpoint_address;
    logic [7:0]  endpoint_attributes;
    logic [15:0] max_packet_size;
    logic [7:0]  poll_interval;
    logic        finished;
    logic        stop_cause;
  } result_t;

endpackage

[sv/ucdscan_in_stage.sv]
module ucdscan_in_stage
  import ucdscan_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  input  item_t s_item,
  input  logic  out_free,
  output logic  in_valid,
  output item_t item
);

  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= s_item;
    end
  end

endmodule

[sv/ucdscan_core.sv]
module ucdscan_core
  import ucdscan_pkg::*;
#(
  parameter int SLOTS        = SLOTS_DEFAULT,
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 take,
  input  item_t                item,
  output logic                 res_valid,
  output result_t              res
);

  localparam int OFS_W = $clog2(BUFFER_BYTES + 260);

  logic [7:0] first_slot_if;
  logic [7:0] last_slot_if;

  logic [OFS_W-1:0] byte_offset;
  logic [OFS_W-1:0] total_length;
  logic [OFS_W-1:0] desc_start;
  logic [7:0]       desc_length;
  logic [7:0]       desc_kind;
  logic [7:0]       current_interface;
  logic [7:0]       held_address;
  logic [7:0]       held_attributes;
  logic [15:0]      held_packet_size;
  logic             scan_stopped;
  logic             header_deferred;

  logic [OFS_W-1:0] byte_offset_next;
  logic [OFS_W-1:0] total_length_next;
  logic [OFS_W-1:0] desc_start_next;
  logic [7:0]       desc_length_next;
  logic [7:0]       desc_kind_next;
  logic [7:0]       current_interface_next;
  logic [7:0]       held_address_next;
  logic [7:0]       held_attributes_next;
  logic [15:0]      held_packet_size_next;
  logic             header_deferred_next;

  logic             active;
  logic [7:0]       b;
  logic [OFS_W-1:0] o;
  logic [OFS_W-1:0] start;
  logic [OFS_W-1:0] rel;
  logic [OFS_W-1:0] hpos;
  logic [OFS_W-1:0] next_start;
  logic [15:0]      total_raw;
  logic [7:0]       cur_iface;
  logic [7:0]       slot;
  logic             fin;
  logic             cause;
  logic             map;
  logic             deferred_chk;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_slot_if <= FIRST_SLOT_IF_RESET;
      last_slot_if  <= LAST_SLOT_IF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIRST_SLOT_IF: first_slot_if <= cfg_data;
        REG_LAST_SLOT_IF:  last_slot_if  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    b      = item.desc_byte;
    active = item.restart || !scan_stopped;

    // restart begins a fresh scan with this byte at offset zero
    o                     = item.restart ? '0 : byte_offset;
    start                 = item.restart ? '0 : desc_start;
    total_length_next     = item.restart ? '0 : total_length;
    desc_length_next      = item.restart ? '0 : desc_length;
    desc_kind_next        = item.restart ? '0 : desc_kind;
    cur_iface             = item.restart ? IFACE_NONE : current_interface;
    held_address_next     = item.restart ? '0 : held_address;
    held_attributes_next  = item.restart ? '0 : held_attributes;
    held_packet_size_next = item.restart ? '0 : held_packet_size;
    header_deferred_next  = item.restart ? 1'b0 : header_deferred;
    current_interface_next = cur_iface;
    desc_start_next       = start;
    byte_offset_next      = o + OFS_W'(1);

    total_raw = {b, total_length_next[7:0]};
    if (o == OFS_W'(TOTAL_LO_OFS)) begin
      total_length_next = OFS_W'(b);
    end else if (o == OFS_W'(TOTAL_HI_OFS)) begin
      if ({1'b0, total_raw} > 17'(BUFFER_BYTES)) begin
        total_length_next = OFS_W'(BUFFER_BYTES);
      end else begin
        total_length_next = total_raw[OFS_W-1:0];
      end
    end

    rel = o - start;
    if (rel == '0) begin
      desc_length_next = b;
    end else if (rel == OFS_W'(1)) begin
      desc_kind_next = b;
    end else if (rel == OFS_W'(REL_ADDR)) begin
      held_address_next = b;
    end else if (rel == OFS_W'(REL_ATTR)) begin
      held_attributes_next = b;
    end else if (rel == OFS_W'(REL_MPS_LO)) begin
      held_packet_size_next = {8'h00, b};
    end else if (rel == OFS_W'(REL_MPS_HI)) begin
      held_packet_size_next = {b, held_packet_size_next[7:0]};
    end

    fin   = 1'b0;
    cause = CAUSE_USED_UP;

    // header of a short first descriptor, checked once the total is known
    deferred_chk = (o == OFS_W'(TOTAL_HI_OFS)) && header_deferred_next;
    if (deferred_chk) begin
      header_deferred_next = 1'b0;
      if (total_length_next < OFS_W'(MIN_HDR_LEN)) begin
        fin = 1'b1;
        cause = CAUSE_USED_UP;
      end else if (start > total_length_next) begin
        fin = 1'b1;
        cause = CAUSE_MALFORMED;
      end else if (start + OFS_W'(2) > total_length_next) begin
        fin = 1'b1;
        cause = CAUSE_USED_UP;
      end
    end

    hpos = (start + OFS_W'(1) < OFS_W'(TOTAL_HI_OFS)) ? OFS_W'(TOTAL_HI_OFS)
                                                      : start + OFS_W'(1);
    if (!fin && o == hpos) begin
      if (start + OFS_W'(2) > total_length_next) begin
        fin = 1'b1;
        cause = CAUSE_USED_UP;
      end else if (desc_length_next < MIN_HDR_LEN ||
                   start + OFS_W'(desc_length_next) > total_length_next) begin
        fin = 1'b1;
        cause = CAUSE_MALFORMED;
      end
    end

    slot = cur_iface - first_slot_if;
    map  = !fin && rel == OFS_W'(REL_INTERVAL) && desc_kind_next == DESC_ENDPOINT &&
           desc_length_next >= MIN_EP_LEN &&
           cur_iface >= first_slot_if && cur_iface <= last_slot_if &&
           held_address_next[EP_DIR_IN_BIT] &&
           held_attributes_next[1:0] == XFER_INTERRUPT &&
           {1'b0, slot} < 9'(SLOTS);

    next_start = start + OFS_W'(desc_length_next);
    if (!fin && desc_length_next >= MIN_HDR_LEN &&
        rel == OFS_W'(desc_length_next - 8'd1)) begin
      if (desc_kind_next == DESC_INTERFACE && desc_length_next >= MIN_IF_LEN) begin
        current_interface_next = held_address_next;
      end
      if (o < OFS_W'(TOTAL_HI_OFS)) begin
        header_deferred_next = 1'b1;
        desc_start_next = next_start;
      end else if (next_start + OFS_W'(2) > total_length_next) begin
        fin = 1'b1;
        cause = CAUSE_USED_UP;
      end else begin
        desc_start_next = next_start;
      end
    end

    res_valid               = active && (map || fin);
    res.map_valid           = map;
    res.slot_index          = map ? slot[1:0] : 2'd0;
    res.endpoint_address    = map ? held_address_next : 8'd0;
    res.endpoint_attributes = map ? held_attributes_next : 8'd0;
    res.max_packet_size     = map ? held_packet_size_next : 16'd0;
    res.poll_interval       = map ? b : 8'd0;
    res.finished            = fin;
    res.stop_cause          = fin ? cause : CAUSE_USED_UP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_stopped <= 1'b1;
    end else if (take && active) begin
      scan_stopped <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (take && active) begin
      byte_offset       <= byte_offset_next;
      total_length      <= total_length_next;
      desc_start        <= desc_start_next;
      desc_length       <= desc_length_next;
      desc_kind         <= desc_kind_next;
      current_interface <= current_interface_next;
      held_address      <= held_address_next;
      held_attributes   <= held_attributes_next;
      held_packet_size  <= held_packet_size_next;
      header_deferred   <= header_deferred_next;
    end
  end

  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    take && scan_stopped && !item.restart |-> !res_valid)
    else $error("result while scan idle");

  a_fin_stops: assert property (@(posedge clk) disable iff (rst)
    take && res_valid && res.finished |=> scan_stopped)
    else $error("scan still running after finish");

  a_start_behind: assert property (@(posedge clk) disable iff (rst)
    !scan_stopped |-> desc_start <= byte_offset)
    else $error("descriptor start ahead of offset");

  a_deferred_early: assert property (@(posedge clk) disable iff (rst)
    !scan_stopped && header_deferred |->
      byte_offset == OFS_W'(TOTAL_LO_OFS) || byte_offset == OFS_W'(TOTAL_HI_OFS))
    else $error("deferred header check pending past total length");

endmodule

[sv/ucdscan_out_stage.sv]
module ucdscan_out_stage
  import ucdscan_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    take,
  input  logic    res_valid,
  input  result_t res,
  output logic    out_free,
  output logic    m_tvalid,
  input  logic    m_tready,
  output result_t m_res
);

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= take && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && take && res_valid) begin
      m_res <= res;
    end
  end

endmodule

[sv/usb_config_descriptor_endpoint_scan_unit.sv]
// Scans a USB configuration descriptor set arriving one byte per transfer
// (restart in s_tuser marks offset zero) and reports each interrupt-IN
// endpoint of an interface inside the configured slot window, plus one
// final transfer with tlast when the scan ends (stop cause in m_tuser[1]).
// One byte is accepted every clock unless the output stalls; each byte is
// held in the input register and its result in the result register, and
// s_tready follows m_tready combinationally when both registers are full.
// Bytes without restart after the scan has ended are consumed silently.
module usb_config_descriptor_endpoint_scan_unit
  import ucdscan_pkg::*;
#(
  parameter int SLOTS        = SLOTS_DEFAULT,
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,  // desc_byte
  input  logic                 s_tuser,  // restart
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [47:0]          m_tdata,  // slot_index, endpoint_address,
                                         // endpoint_attributes, max_packet_size,
                                         // poll_interval, zero fill
  output logic [1:0]           m_tuser,  // map_valid, stop_cause
  output logic                 m_tlast   // finished
);

  item_t   s_item;
  item_t   item;
  logic    in_valid;
  logic    out_free;
  logic    take;
  logic    res_valid;
  result_t res;
  result_t m_res;

  assign s_item.desc_byte = s_tdata;
  assign s_item.restart   = s_tuser;
  assign take             = in_valid && out_free;

  ucdscan_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_item   (s_item),
    .out_free (out_free),
    .in_valid (in_valid),
    .item     (item)
  );

  ucdscan_core #(
    .SLOTS        (SLOTS),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  ucdscan_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_res     (m_res)
  );

  assign m_tdata = {6'd0, m_res.poll_interval, m_res.max_packet_size,
                    m_res.endpoint_attributes, m_res.endpoint_address,
                    m_res.slot_index};
  assign m_tuser = {m_res.stop_cause, m_res.map_valid};
  assign m_tlast = m_res.finished;

endmodule

[tb/usb_config_descriptor_endpoint_scan_unit_test.sv]
`timescale 1ns / 100ps

module usb_config_descriptor_endpoint_scan_unit_test;
  import ucdscan_pkg::*;

  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned LONG_STALL      = 80;
  localparam int unsigned ITEMS_PER_PHASE = 160;
  localparam int unsigned PHASES          = 6;
  localparam int unsigned REL_LEN         = 0;
  localparam int unsigned REL_KIND        = 1;
  localparam logic [7:0]  DESC_CONFIG     = 8'h02;
  localparam logic [7:0]  DESC_HID        = 8'h21;
  localparam logic [7:0]  CONFIG_DESC_LEN = 8'd9;
  localparam logic [7:0]  HID_DESC_LEN    = 8'd9;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [47:0]          m_tdata;
  logic [1:0]           m_tuser;
  logic                 m_tlast;

  usb_config_descriptor_endpoint_scan_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  item_t       pending_bytes[$];
  result_t     expected_reports[$];
  bit [7:0]    set_bytes[$];
  int unsigned mismatch_count = 0;
  int unsigned send_gap_pct = 19;
  int unsigned recv_gap_pct = 63;
  int unsigned long_stall_req = 0;
  int unsigned long_stall_seen = 0;
  int unsigned stall_left = 0;
  item_t       next_item;
  result_t     seen, want;

  // scan state
  int unsigned scan_pos, set_total, hdr_start;
  bit [7:0]    hdr_len, hdr_kind, active_iface, ep_addr, ep_attr;
  bit [15:0]   ep_mps;
  bit          scan_idle, hdr_pending;
  bit [7:0]    cfg_first_if, cfg_last_if;

  bit [8:0] directed_items [25] = '{
    9'h000, 9'h0ff,
    // short first descriptor, total overlaps the interface header, clamps
    9'h102, 9'h002, 9'h009, 9'h004, 9'h003, 9'h000, 9'h001, 9'h003, 9'h000,
    9'h001, 9'h000, 9'h007, 9'h005, 9'h0ff, 9'h0ff, 9'h0ff, 9'h0ff, 9'h0ff,
    // restart mid-scan, total of 1 ends it
    9'h104, 9'h002, 9'h001, 9'h000,
    9'h000
  };
  bit [7:0] phase_first [PHASES] = '{8'd2, 8'd0, 8'd6, 8'd255, 8'd0, 8'd4};
  bit [7:0] phase_last  [PHASES] = '{8'd5, 8'd255, 8'd1, 8'd255, 8'd0, 8'd7};

  function automatic void clear_scan();
    scan_pos     = 0;
    set_total    = 0;
    hdr_start    = 0;
    hdr_len      = 0;
    hdr_kind     = 0;
    active_iface = IFACE_NONE;
    ep_addr      = 0;
    ep_attr      = 0;
    ep_mps       = 0;
    hdr_pending  = 0;
  endfunction

  function automatic void scan_descriptor_byte(bit restart, bit [7:0] b);
    int unsigned o, rel, hpos, nxt, slot;
    bit          fin, cause;
    result_t     r;
    fin   = 1'b0;
    cause = CAUSE_USED_UP;
    r     = '0;
    if (restart) begin
      clear_scan();
      scan_idle = 1'b0;
    end else if (scan_idle) begin
      return;
    end
    o = scan_pos;
    if (o == TOTAL_LO_OFS) begin
      set_total = 32'(b);
    end else if (o == TOTAL_HI_OFS) begin
      set_total = set_total | (int'(b) << 8);
      if (set_total > BUFFER_BYTES_DEFAULT) set_total = BUFFER_BYTES_DEFAULT;
    end
    rel = o - hdr_start;
    case (rel)
      REL_LEN:    hdr_len = b;
      REL_KIND:   hdr_kind = b;
      REL_ADDR:   ep_addr = b;
      REL_ATTR:   ep_attr = b;
      REL_MPS_LO: ep_mps = {8'h00, b};
      REL_MPS_HI: ep_mps[15:8] = b;
      default: ;
    endcase
    if (o == TOTAL_HI_OFS && hdr_pending) begin
      hdr_pending = 1'b0;
      if (set_total < MIN_HDR_LEN) begin
        fin = 1'b1; cause = CAUSE_USED_UP;
      end else if (hdr_start > set_total) begin
        fin = 1'b1; cause = CAUSE_MALFORMED;
      end else if (hdr_start + MIN_HDR_LEN > set_total) begin
        fin = 1'b1; cause = CAUSE_USED_UP;
      end
    end
    // header is judged at its type byte, or once the total is known
    hpos = (hdr_start + 1 < TOTAL_HI_OFS) ? TOTAL_HI_OFS : hdr_start + 1;
    if (!fin && o == hpos) begin
      if (hdr_start + MIN_HDR_LEN > set_total) begin
        fin = 1'b1; cause = CAUSE_USED_UP;
      end else if (hdr_len < MIN_HDR_LEN || hdr_start + hdr_len > set_total) begin
        fin = 1'b1; cause = CAUSE_MALFORMED;
      end
    end
    if (!fin && rel == REL_INTERVAL && hdr_kind == DESC_ENDPOINT && hdr_len >= MIN_EP_LEN &&
        active_iface >= cfg_first_if && active_iface <= cfg_last_if &&
        ep_addr[EP_DIR_IN_BIT] && ep_attr[1:0] == XFER_INTERRUPT) begin
      slot = 32'(active_iface) - 32'(cfg_first_if);
      if (slot < SLOTS_DEFAULT) begin
        r.map_valid           = 1'b1;
        r.slot_index          = slot[1:0];
        r.endpoint_address    = ep_addr;
        r.endpoint_attributes = ep_attr;
        r.max_packet_size     = ep_mps;
        r.poll_interval       = b;
      end
    end
    if (!fin && hdr_len >= MIN_HDR_LEN && rel == hdr_len - 1) begin
      nxt = hdr_start + 32'(hdr_len);
      if (hdr_kind == DESC_INTERFACE && hdr_len >= MIN_IF_LEN) active_iface = ep_addr;
      if (o < TOTAL_HI_OFS) begin
        hdr_pending = 1'b1;
        hdr_start   = nxt;
      end else if (nxt + MIN_HDR_LEN > set_total) begin
        fin = 1'b1; cause = CAUSE_USED_UP;
      end else begin
        hdr_start = nxt;
      end
    end
    if (scan_pos < 32'hffff) scan_pos++;
    if (fin) begin
      scan_idle    = 1'b1;
      r.finished   = 1'b1;
      r.stop_cause = cause;
    end
    if (r.map_valid || fin) expected_reports.push_back(r);
  endfunction

  task automatic flag_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string field, logic [15:0] got, logic [15:0] exp_val);
    if (got !== exp_val)
      flag_mismatch($sformatf("%s got %0h, want %0h", field, got, exp_val));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FIRST_SLOT_IF) cfg_first_if = value;
    else cfg_last_if = value;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_bytes.size() != 0 || s_tvalid || expected_reports.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One descriptor set: mostly well-formed with random content, some broken.
  task automatic queue_set(output int unsigned counted);
    int unsigned shape, len, tot, cut, i;
    bit [7:0]    value, iface;
    bit          noise;
    set_bytes.delete();
    shape = $urandom_range(99);
    noise = (shape < 15);
    if (noise) begin
      repeat ($urandom_range(1, 40)) begin
        value = 8'($urandom_range(255));
        set_bytes.push_back(value);
      end
    end else begin
      if (shape < 30) begin
        len = $urandom_range(2, 3);
        set_bytes.push_back(8'(len));
        for (i = 1; i < len; i++) begin
          value = 8'($urandom_range(255));
          set_bytes.push_back(value);
        end
      end else begin
        set_bytes.push_back(CONFIG_DESC_LEN);
        set_bytes.push_back(DESC_CONFIG);
        for (i = 2; i < CONFIG_DESC_LEN; i++) begin
          value = 8'($urandom_range(255));
          set_bytes.push_back(value);
        end
      end
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(9))
          0:       iface = 8'($urandom_range(255));
          1, 2:    iface = 8'($urandom_range(9));
          default: iface = cfg_first_if + 8'($urandom_range(5));
        endcase
        len = ($urandom_range(19) == 0) ? 32'(MIN_IF_LEN) - 1 : 32'(MIN_IF_LEN);
        set_bytes.push_back(8'(len));
        set_bytes.push_back(DESC_INTERFACE);
        set_bytes.push_back(iface);
        for (i = 3; i < len; i++) begin
          value = 8'($urandom_range(255));
          set_bytes.push_back(value);
        end
        if ($urandom_range(2) == 0) begin
          set_bytes.push_back(HID_DESC_LEN);
          set_bytes.push_back(DESC_HID);
          for (i = 2; i < HID_DESC_LEN; i++) begin
            value = 8'($urandom_range(255));
            set_bytes.push_back(value);
          end
        end
        repeat ($urandom_range(1, 3)) begin
          len = ($urandom_range(9) == 0) ? $urandom_range(4, 10) : 32'(MIN_EP_LEN);
          set_bytes.push_back(8'(len));
          set_bytes.push_back(DESC_ENDPOINT);
          for (i = 2; i < len; i++) begin
            value = 8'($urandom_range(255));
            if (i == REL_ADDR && $urandom_range(3) != 0)
              value[EP_DIR_IN_BIT] = 1'b1;
            if (i == REL_ATTR && $urandom_range(3) != 0)
              value[1:0] = XFER_INTERRUPT;
            set_bytes.push_back(value);
          end
        end
      end
      if (shape >= 30) begin
        case ($urandom_range(9))
          0:       tot = $urandom_range(0, set_bytes.size());
          1:       tot = $urandom_range(set_bytes.size(), 32'hffff);
          default: tot = set_bytes.size();
        endcase
        set_bytes[TOTAL_LO_OFS] = tot[7:0];
        set_bytes[TOTAL_HI_OFS] = tot[15:8];
      end
    end
    if ($urandom_range(9) == 0)
      set_bytes[$urandom_range(set_bytes.size() - 1)] = 8'($urandom_range(12));
    if ($urandom_range(9) == 0) begin
      cut = $urandom_range(1, set_bytes.size());
      while (set_bytes.size() > cut) void'(set_bytes.pop_back());
    end
    for (i = 0; i < set_bytes.size(); i++)
      pending_bytes.push_back({i == 0 || (noise && $urandom_range(19) == 0), set_bytes[i]});
    counted = set_bytes.size();
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        value = 8'($urandom_range(255));
        pending_bytes.push_back({1'b0, value});
      end
    end
  endtask

  // input side
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) scan_descriptor_byte(s_tuser, s_tdata);
      if (!s_tvalid || s_tready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          next_item = pending_bytes.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= next_item.desc_byte;
          s_tuser  <= next_item.restart;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side: check each result transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_reports.size() == 0) begin
          flag_mismatch($sformatf("unexpected result tdata %h tuser %b tlast %b",
                                  m_tdata, m_tuser, m_tlast));
        end else begin
          want = expected_reports.pop_front();
          seen.map_valid           = m_tuser[0];
          seen.slot_index          = m_tdata[1:0];
          seen.endpoint_address    = m_tdata[9:2];
          seen.endpoint_attributes = m_tdata[17:10];
          seen.max_packet_size     = m_tdata[33:18];
          seen.poll_interval       = m_tdata[41:34];
          seen.finished            = m_tlast;
          seen.stop_cause          = m_tuser[1];
          check_field("map_valid", 16'(seen.map_valid), 16'(want.map_valid));
          check_field("slot_index", 16'(seen.slot_index), 16'(want.slot_index));
          check_field("endpoint_address", 16'(seen.endpoint_address),
                      16'(want.endpoint_address));
          check_field("endpoint_attributes", 16'(seen.endpoint_attributes),
                      16'(want.endpoint_attributes));
          check_field("max_packet_size", seen.max_packet_size, want.max_packet_size);
          check_field("poll_interval", 16'(seen.poll_interval), 16'(want.poll_interval));
          check_field("finished", 16'(seen.finished), 16'(want.finished));
          check_field("stop_cause", 16'(seen.stop_cause), 16'(want.stop_cause));
        end
      end
      if (long_stall_seen != long_stall_req) begin
        long_stall_seen <= long_stall_req;
        stall_left      <= LONG_STALL;
        m_tready        <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        m_tready   <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  // watchdog: no transfer on either side for too long
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("[usb_config_descriptor_endpoint_scan_unit] ERROR");
    $finish;
  end

  initial begin
    int unsigned phase, pushed, n;
    bit          paused;
    clear_scan();
    scan_idle    = 1'b1;
    cfg_first_if = FIRST_SLOT_IF_RESET;
    cfg_last_if  = LAST_SLOT_IF_RESET;
    paused       = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_items[i]) pending_bytes.push_back(directed_items[i]);
    wait_drained();
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase == 2) begin
        send_gap_pct = 63;
        recv_gap_pct = 19;
      end else if (phase == 4) begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      write_reg(REG_FIRST_SLOT_IF, phase_first[phase]);
      write_reg(REG_LAST_SLOT_IF, phase_last[phase]);
      if (phase == 0) long_stall_req++;
      pushed = 0;
      while (pushed < ITEMS_PER_PHASE) begin
        if (phase == 1 && !paused && pushed >= ITEMS_PER_PHASE / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        queue_set(n);
        pushed += n;
      end
      wait_drained();
    end
    if (mismatch_count == 0) begin
      $display("[usb_config_descriptor_endpoint_scan_unit] OK");
    end else begin
      $display("[usb_config_descriptor_endpoint_scan_unit] ERROR");
    end
    $finish;
  end

endmodule
